[hw/rtl/lac_pkg.sv]
// Shared types and constants for the lift actuator controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lac_pkg;

	localparam int DEB_W      = 8;
	localparam int RUN_W      = 16;
	localparam int TICK_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DEB_W-1:0]  DEB_ON_RST    = DEB_W'(50);
	localparam logic [DEB_W-1:0]  DEB_OFF_RST   = DEB_W'(50);
	localparam logic [RUN_W-1:0]  UP_LIMIT_RST  = RUN_W'(60);
	localparam logic [RUN_W-1:0]  DN_LIMIT_RST  = RUN_W'(60);
	localparam logic [RUN_W-1:0]  SLEEP_RST     = RUN_W'(300);
	localparam logic [TICK_W-1:0] TPS_RST       = TICK_W'(1000);

	// Press mask codes
	localparam logic [3:0] MASK_NONE = 4'b0000;
	localparam logic [3:0] MASK_UP   = 4'b0001;
	localparam logic [3:0] MASK_DOWN = 4'b0010;
	localparam logic [3:0] MASK_C    = 4'b0100;
	localparam logic [3:0] MASK_D    = 4'b1000;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_UPLIMIT = 2'd2,
		MODE_TIMEOUT = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEB_ON   = 3'd0,
		REG_DEB_OFF  = 3'd1,
		REG_UP_LIMIT = 3'd2,
		REG_DN_LIMIT = 3'd3,
		REG_SLEEP    = 3'd4,
		REG_TPS      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DEB_W-1:0]  deb_on;
		logic [DEB_W-1:0]  deb_off;
		logic [RUN_W-1:0]  up_limit;
		logic [RUN_W-1:0]  dn_limit;
		logic [RUN_W-1:0]  sleep_after;
		logic [TICK_W-1:0] tps;
	} cfg_t;

	typedef struct packed {
		logic up_button;
		logic up_remote_n;
		logic down_button;
		logic down_remote_n;
		logic remote_c;
		logic remote_d;
	} raw_btn_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] mask;
	} deb_stat_t;

	typedef struct packed {
		logic  up_on;
		logic  down_on;
		mode_t mode;
		logic  sleep;
	} motion_t;

endpackage

`default_nettype wire

[hw/rtl/lift_actuator_controller.sv]
// Top level of the lift actuator controller: config registers, handshake, result register.
// Depends on lac_pkg, lac_debounce and lac_motion.
`default_nettype none

// One request is one millisecond tick of raw button, remote and limit-switch
// levels. The block takes a tick in every clock cycle while results are taken:
// the debounce counters, state machine and timers update from the accepted
// tick, and the result appears in the output register on the next cycle. A result
// that is not taken holds the input off until it is taken; a new tick is
// accepted in the same cycle that the waiting result leaves. Configuration
// writes are accepted at once, at any time; write only while no tick is in
// flight. Register indexes 6 and 7 are ignored.
module lift_actuator_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lac_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             up_button,
	input  wire logic                             up_remote_n,
	input  wire logic                             down_button,
	input  wire logic                             down_remote_n,
	input  wire logic                             remote_c,
	input  wire logic                             remote_d,
	input  wire logic                             up_travel_free,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  up_drive,
	output logic                                  down_drive,
	output logic [1:0]                            lift_state,
	output logic [3:0]                            debounced_buttons,
	output logic                                  debounce_busy,
	output logic                                  sleep_request
);
	import lac_pkg::*;

	cfg_t      cfg_q;
	raw_btn_t  raw;
	deb_stat_t deb;
	motion_t   nxt;
	logic      step;
	logic      out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deb_on      <= DEB_ON_RST;
			cfg_q.deb_off     <= DEB_OFF_RST;
			cfg_q.up_limit    <= UP_LIMIT_RST;
			cfg_q.dn_limit    <= DN_LIMIT_RST;
			cfg_q.sleep_after <= SLEEP_RST;
			cfg_q.tps         <= TPS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEB_ON:   cfg_q.deb_on      <= cfg_data[DEB_W-1:0];
				REG_DEB_OFF:  cfg_q.deb_off     <= cfg_data[DEB_W-1:0];
				REG_UP_LIMIT: cfg_q.up_limit    <= cfg_data[RUN_W-1:0];
				REG_DN_LIMIT: cfg_q.dn_limit    <= cfg_data[RUN_W-1:0];
				REG_SLEEP:    cfg_q.sleep_after <= cfg_data[RUN_W-1:0];
				REG_TPS:      cfg_q.tps         <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	assign raw.up_button     = up_button;
	assign raw.up_remote_n   = up_remote_n;
	assign raw.down_button   = down_button;
	assign raw.down_remote_n = down_remote_n;
	assign raw.remote_c      = remote_c;
	assign raw.remote_d      = remote_d;

	lac_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.raw    (raw),
		.cfg    (cfg_q),
		.stat   (deb)
	);

	lac_motion u_motion (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.deb            (deb),
		.up_travel_free (up_travel_free),
		.cfg            (cfg_q),
		.nxt            (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			up_drive          <= nxt.up_on;
			down_drive        <= nxt.down_on;
			lift_state        <= nxt.mode;
			debounced_buttons <= deb.accepted ? deb.mask : MASK_NONE;
			debounce_busy     <= !deb.accepted;
			sleep_request     <= nxt.sleep;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_busy_no_buttons: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && debounce_busy |-> debounced_buttons == MASK_NONE)
		else $error("buttons reported while debounce busy");

	a_drive_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((lift_state == MODE_RUNNING) == (up_drive ^ down_drive)) &&
			!(up_drive && down_drive))
		else $error("solenoid drive inconsistent with lift state");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire

[hw/rtl/lac_debounce.sv]
// Press mask merge and on/off debounce counters.
// Depends on lac_pkg.
`default_nettype none

module lac_debounce (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire lac_pkg::raw_btn_t raw,
	input  wire lac_pkg::cfg_t     cfg,
	output lac_pkg::deb_stat_t     stat
);
	import lac_pkg::*;

	logic [3:0]       mask;
	logic             single;
	logic [DEB_W-1:0] press_q, release_q;
	logic [DEB_W-1:0] press_d, release_d;

	always_comb begin
		mask = {raw.remote_d, raw.remote_c,
			raw.down_button | ~raw.down_remote_n,
			raw.up_button | ~raw.up_remote_n};
		single = (mask == MASK_UP) || (mask == MASK_DOWN) ||
			(mask == MASK_C) || (mask == MASK_D);
		press_d   = press_q;
		release_d = release_q;
		if (mask == MASK_NONE) begin
			press_d = '0;
			if (release_q < cfg.deb_off)
				release_d = release_q + DEB_W'(1);
		end else if (single) begin
			release_d = '0;
			if (press_q < cfg.deb_on)
				press_d = press_q + DEB_W'(1);
		end else begin
			// several presses: restart both
			press_d   = '0;
			release_d = '0;
		end
		stat.mask     = mask;
		stat.accepted = (press_d >= cfg.deb_on) || (release_d >= cfg.deb_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= '0;
			release_q <= '0;
		end else if (step) begin
			press_q   <= press_d;
			release_q <= release_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lac_motion.sv]
// Lift state machine, run timer, seconds prescaler and inactivity counter.
// Depends on lac_pkg; fed by lac_debounce.
`default_nettype none

module lac_motion (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire lac_pkg::deb_stat_t deb,
	input  wire logic               up_travel_free,
	input  wire lac_pkg::cfg_t      cfg,
	output lac_pkg::motion_t        nxt
);
	import lac_pkg::*;

	mode_t             mode_q, mode_d;
	logic              up_q, up_d, dn_q, dn_d;
	logic [RUN_W-1:0]  run_q, run_d;
	logic [RUN_W-1:0]  idle_q, idle_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic              sleep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			up_q   <= 1'b0;
			dn_q   <= 1'b0;
			run_q  <= '0;
			idle_q <= '0;
			tick_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			up_q   <= up_d;
			dn_q   <= dn_d;
			run_q  <= run_d;
			idle_q <= idle_d;
			tick_q <= tick_d;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		up_d    = up_q;
		dn_d    = dn_q;
		run_d   = run_q;
		idle_d  = idle_q;
		tick_d  = tick_q + TICK_W'(1);
		sleep_d = 1'b0;

		if (deb.accepted) begin
			if (deb.mask == MASK_NONE) begin
				up_d   = 1'b0;
				dn_d   = 1'b0;
				mode_d = MODE_IDLE;
				run_d  = '0;
			end
			unique case (mode_d)
				MODE_IDLE: begin
					if (deb.mask == MASK_UP && !up_travel_free) begin
						mode_d = MODE_UPLIMIT;
					end else if (deb.mask == MASK_UP) begin
						dn_d   = 1'b0;
						up_d   = 1'b1;
						mode_d = MODE_RUNNING;
						run_d  = cfg.up_limit;
					end else if (deb.mask == MASK_DOWN) begin
						up_d   = 1'b0;
						dn_d   = 1'b1;
						mode_d = MODE_RUNNING;
						run_d  = cfg.dn_limit;
					end
				end
				MODE_RUNNING: begin
					if (deb.mask == MASK_UP && !up_travel_free) begin
						up_d   = 1'b0;
						dn_d   = 1'b0;
						mode_d = MODE_UPLIMIT;
					end
					// timeout wins over the limit switch
					if (run_d == RUN_W'(1)) begin
						up_d   = 1'b0;
						dn_d   = 1'b0;
						mode_d = MODE_TIMEOUT;
					end
				end
				default: begin
				end
			endcase
			if (mode_d != MODE_IDLE)
				idle_d = '0;
		end

		if (tick_d >= cfg.tps) begin
			tick_d = '0;
			if (run_d != '0)
				run_d = run_d - RUN_W'(1);
			if (idle_d < cfg.sleep_after)
				idle_d = idle_d + RUN_W'(1);
			if (idle_d >= cfg.sleep_after) begin
				idle_d  = '0;
				sleep_d = 1'b1;
			end
		end

		nxt.up_on   = up_d;
		nxt.down_on = dn_d;
		nxt.mode    = mode_d;
		nxt.sleep   = sleep_d;
	end

endmodule

`default_nettype wire
